// ===== src/brfhs_pkg.sv =====
package brfhs_pkg;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int DATA_W    = 8;
  localparam int AMT_W     = 12;
  localparam int OCC_W     = 12;
  localparam int PAT_W     = 32;
  localparam int HSIZE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int HAVE_W    = 3;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 3'd0,
    OP_GET   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_ADV   = 3'd3,
    OP_CLEAR = 3'd4,
    OP_SKIP  = 3'd5
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_SIZE    = 2'd1,
    REG_ENDIAN  = 2'd2
  } reg_idx_t;

  // Header width codes
  localparam logic [HSIZE_W-1:0] HSIZE_ONE = 2'd0;
  localparam logic [HSIZE_W-1:0] HSIZE_TWO = 2'd1;

endpackage

// ===== src/brfhs_ram.sv =====
module brfhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/byte_ring_fifo_header_sync_core.sv =====
// Byte FIFO in a power-of-two ring, with a header search.
//
// Requests arrive on in_valid/in_ready carrying operation, data_in and
// amount; each request gives exactly one result on out_valid/out_ready
// (data_out, ok, occupancy, is_empty, is_full, taken after the operation).
// Configuration (header pattern, size, byte order) is written on
// cfg_valid/cfg_ready, ready whenever reset is low. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Operations: put, advance, clear and unused codes complete from the idle
// state directly; get and peek pass through a read state that takes the
// registered output of the byte RAM. Skip to header fetches the window one
// byte per RAM read (a fetch state per byte), then for each dropped byte
// compares, slides the window and refetches the missing byte.
// A new request is taken only when the sequencer is idle and the result
// register is empty or being emptied in the same cycle; a stalled receiver
// therefore holds off further requests, and the pending result stays put.
// Reset clears the pointers, the configuration and the result valid flag;
// the byte store itself is not cleared and needs no clearing pass.
module byte_ring_fifo_header_sync_core #(
  parameter int DEPTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [brfhs_pkg::OP_W-1:0]        operation,
  input  logic [brfhs_pkg::DATA_W-1:0]      data_in,
  input  logic [brfhs_pkg::AMT_W-1:0]       amount,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [brfhs_pkg::DATA_W-1:0]      data_out,
  output logic                              ok,
  output logic [brfhs_pkg::OCC_W-1:0]       occupancy,
  output logic                              is_empty,
  output logic                              is_full,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [brfhs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brfhs_pkg::PAT_W-1:0]       cfg_data
);

  import brfhs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = (PW > OCC_W) ? PW : OCC_W;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SCAN, ST_FETCH} state_t;

  state_t state, state_next;

  logic [PW-1:0]      wp, wp_next;
  logic [PW-1:0]      rp, rp_next;
  logic [PAT_W-1:0]   header_pattern;
  logic [HSIZE_W-1:0] header_size;
  logic               header_big_endian;

  logic [DATA_W-1:0]  win_b [4];
  logic [HAVE_W-1:0]  have, have_next;
  logic               win_shift, win_fill;
  logic               rd_ok, rd_ok_next;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  logic               load;
  logic [DATA_W-1:0]  res_data;
  logic               res_ok;

  logic               accept;
  logic [PW-1:0]      occ, occ_n;
  logic [CW-1:0]      occ_c, occ_n_c, amt_c, rp_c, pk_c, adv_c;
  logic               full;
  logic [HAVE_W-1:0]  hw;
  logic [PAT_W-1:0]   win, want;

  // Byte store
  brfhs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(wp[AW-1:0]),
    .wr_data(data_in),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Handshakes and fill level
  assign cfg_ready = !rst;
  assign in_ready  = !rst && (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  assign occ     = wp - rp;
  assign occ_n   = wp_next - rp_next;
  assign occ_c   = CW'(occ);
  assign occ_n_c = CW'(occ_n);
  assign amt_c   = CW'(amount);
  assign rp_c    = CW'(rp);
  assign pk_c    = rp_c + amt_c;
  assign adv_c   = (amt_c > occ_c) ? occ_c : amt_c;
  assign full    = (occ == PW'(DEPTH));

  // Header window: width, wanted value, assembled head bytes
  always_comb begin
    case (header_size)
      HSIZE_ONE: begin
        hw   = 3'd1;
        want = {24'd0, header_pattern[7:0]};
        win  = {24'd0, win_b[0]};
      end
      HSIZE_TWO: begin
        hw   = 3'd2;
        want = {16'd0, header_pattern[15:0]};
        win  = header_big_endian ? {16'd0, win_b[0], win_b[1]}
                                 : {16'd0, win_b[1], win_b[0]};
      end
      default: begin
        hw   = 3'd4;
        want = header_pattern;
        win  = header_big_endian ? {win_b[0], win_b[1], win_b[2], win_b[3]}
                                 : {win_b[3], win_b[2], win_b[1], win_b[0]};
      end
    endcase
  end

  // Sequencer next values
  always_comb begin
    state_next = state;
    wp_next    = wp;
    rp_next    = rp;
    have_next  = have;
    rd_ok_next = rd_ok;
    win_shift  = 1'b0;
    win_fill   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rp[AW-1:0];
    load       = 1'b0;
    res_data   = '0;
    res_ok     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_PUT: begin
              load = 1'b1;
              if (!full) begin
                ram_we  = 1'b1;
                wp_next = wp + PW'(1);
                res_ok  = 1'b1;
              end
            end
            OP_GET: begin
              state_next = ST_READ;
              rd_ok_next = (occ != '0);
              if (occ != '0) begin
                ram_re  = 1'b1;
                rp_next = rp + PW'(1);
              end
            end
            OP_PEEK: begin
              state_next = ST_READ;
              ram_raddr  = pk_c[AW-1:0];
              ram_re     = (amt_c < occ_c);
              rd_ok_next = (amt_c < occ_c);
            end
            OP_ADV: begin
              load    = 1'b1;
              rp_next = rp + adv_c[PW-1:0];
            end
            OP_CLEAR: begin
              load    = 1'b1;
              wp_next = '0;
              rp_next = '0;
            end
            OP_SKIP: begin
              state_next = ST_SCAN;
              have_next  = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load       = 1'b1;
        res_ok     = rd_ok;
        res_data   = rd_ok ? ram_rdata : '0;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (occ_c < CW'(hw)) begin
          // too few bytes left for a window: give up
          load       = 1'b1;
          state_next = ST_IDLE;
        end else if (have == hw) begin
          if (win == want) begin
            load       = 1'b1;
            res_ok     = 1'b1;
            state_next = ST_IDLE;
          end else begin
            // drop the head byte and slide the window
            rp_next   = rp + PW'(1);
            win_shift = 1'b1;
            have_next = have - HAVE_W'(1);
          end
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = rp[AW-1:0] + AW'(have);
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        win_fill   = 1'b1;
        have_next  = have + HAVE_W'(1);
        state_next = ST_SCAN;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, pointers, window and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      have      <= '0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      rp    <= rp_next;
      have  <= have_next;
      rd_ok <= rd_ok_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      data_out  <= res_data;
      ok        <= res_ok;
      occupancy <= occ_n_c[OCC_W-1:0];
      is_empty  <= (occ_n == '0);
      is_full   <= (occ_n == PW'(DEPTH));
    end
    if (win_shift) begin
      win_b[0] <= win_b[1];
      win_b[1] <= win_b[2];
      win_b[2] <= win_b[3];
    end
    if (win_fill) begin
      win_b[have[1:0]] <= ram_rdata;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern    <= '0;
      header_size       <= '0;
      header_big_endian <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN: header_pattern    <= cfg_data;
        REG_SIZE:    header_size       <= cfg_data[HSIZE_W-1:0];
        REG_ENDIAN:  header_big_endian <= cfg_data[0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // fill level never exceeds the ring
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= PW'(DEPTH))
    else $error("occupancy beyond depth");

  // an accepted put with room advances the write pointer by one
  a_put_adv: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_PUT && !full) |=> (wp == $past(wp) + PW'(1)))
    else $error("put did not advance write pointer");

  // the window never holds more bytes than its width
  a_have_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_FETCH) |-> (have <= hw))
    else $error("header window overfilled");
`endif

endmodule
